// ===== sv/rpn_pkg.sv =====
// shared types, constants and decode helpers for the postfix evaluator
// used by rpn_ctrl, rpn_datapath, the top level and the checker
package rpn_pkg;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_UNDER = 2'd1;
   localparam logic [1:0] STS_OVER  = 2'd2;
   localparam logic [1:0] STS_DIVZ  = 2'd3;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ITER,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       push;
      logic       emit;
      logic       set_err;
      logic [1:0] err_code;
      logic       fetch;
      logic       exec;
      logic       iter;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic   has_err;
      logic   lt2;
      logic   full;
      logic   divz;
      logic   iter_done;
      op_type op;
   } stat_type;

   function automatic logic is_operator(input logic [7:0] c);
      is_operator = (c == CHAR_PLUS) || (c == CHAR_MINUS) ||
                    (c == CHAR_STAR) || (c == CHAR_SLASH);
   endfunction

   function automatic op_type decode_op(input logic [7:0] c);
      op_type o;
      case (c)
         CHAR_PLUS:  o = OP_ADD;
         CHAR_MINUS: o = OP_SUB;
         CHAR_STAR:  o = OP_MUL;
         default:    o = OP_DIV;
      endcase
      decode_op = o;
   endfunction

endpackage

// ===== sv/rpn_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rpn_datapath.sv =====
// operand stack (top register plus ram), shift-add multiplier, restoring divider
// and result register; depends on rpn_pkg and rpn_ram
module rpn_datapath #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  rpn_pkg::cmd_type  cmd,
   input  logic [7:0]        char_code,
   output rpn_pkg::stat_type stat,
   output logic [31:0]       value,
   output logic [1:0]        status
);
   import rpn_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(VALUE_WIDTH);
   localparam int W  = VALUE_WIDTH;

   logic [W-1:0]  top_ff, top_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    err_ff, err_in;
   op_type        op_ff, op_in;
   logic [W-1:0]  work_a_ff, work_a_in;
   logic [W-1:0]  work_b_ff, work_b_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic          neg_ff, neg_in;
   logic [IW-1:0] iter_ff, iter_in;
   logic [31:0]   out_value_ff, out_value_in;
   logic [1:0]    out_status_ff, out_status_in;

   logic          ram_wen;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [W-1:0]  lower;
   logic [W-1:0]  push_val, abs_a, abs_b, quot;
   logic [W:0]    shifted, diff;
   logic signed [63:0] top_ext;

   // top of stack lives in top_ff, entries below it in the ram
   assign ram_wen   = cmd.push && (count_ff != '0);
   assign ram_waddr = AW'(count_ff - CW'(1));
   assign ram_raddr = AW'(count_ff - CW'(2));

   rpn_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (ram_waddr),
      .wdata (top_ff),
      .raddr (ram_raddr),
      .rdata (lower)
   );

   always_comb begin
      push_val = W'(char_code) - W'(CHAR_ZERO);
      abs_a    = lower[W-1] ? (W'(0) - lower) : lower;
      abs_b    = top_ff[W-1] ? (W'(0) - top_ff) : top_ff;
      shifted  = {acc_ff, work_a_ff[W-1]};
      diff     = shifted - {1'b0, work_b_ff};
      quot     = neg_ff ? (W'(0) - work_a_ff) : work_a_ff;
      top_ext  = 64'(signed'(top_ff));

      top_in        = top_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      work_a_in     = work_a_ff;
      work_b_in     = work_b_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      iter_in       = iter_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;

      if (cmd.emit) begin
         if (err_ff != STS_OK) begin
            out_value_in  = '0;
            out_status_in = err_ff;
         end else if (count_ff == '0) begin
            out_value_in  = '0;
            out_status_in = STS_UNDER;
         end else begin
            out_value_in  = top_ext[31:0];
            out_status_in = STS_OK;
         end
         count_in = '0;
         err_in   = STS_OK;
      end

      if (cmd.set_err) begin
         err_in = cmd.err_code;
      end

      if (cmd.push) begin
         top_in   = push_val;
         count_in = count_ff + CW'(1);
      end

      if (cmd.fetch) begin
         op_in = decode_op(char_code);
      end

      if (cmd.exec) begin
         iter_in = '0;
         acc_in  = '0;
         case (op_ff)
            OP_ADD: begin
               top_in   = lower + top_ff;
               count_in = count_ff - CW'(1);
            end
            OP_SUB: begin
               top_in   = lower - top_ff;
               count_in = count_ff - CW'(1);
            end
            OP_MUL: begin
               work_a_in = lower;
               work_b_in = top_ff;
            end
            default: begin
               work_a_in = abs_a;
               work_b_in = abs_b;
               neg_in    = lower[W-1] ^ top_ff[W-1];
            end
         endcase
      end

      if (cmd.iter) begin
         iter_in = iter_ff + IW'(1);
         if (op_ff == OP_MUL) begin
            if (work_b_ff[0]) begin
               acc_in = acc_ff + work_a_ff;
            end
            work_a_in = {work_a_ff[W-2:0], 1'b0};
            work_b_in = {1'b0, work_b_ff[W-1:1]};
         end else begin
            // restoring step, quotient bits shift into work_a
            if (!diff[W]) begin
               acc_in    = diff[W-1:0];
               work_a_in = {work_a_ff[W-2:0], 1'b1};
            end else begin
               acc_in    = shifted[W-1:0];
               work_a_in = {work_a_ff[W-2:0], 1'b0};
            end
         end
      end

      if (cmd.finish) begin
         top_in   = (op_ff == OP_MUL) ? acc_ff : quot;
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= STS_OK;
         iter_ff  <= '0;
         op_ff    <= OP_ADD;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
         iter_ff  <= iter_in;
         op_ff    <= op_in;
      end
      top_ff        <= top_in;
      work_a_ff     <= work_a_in;
      work_b_ff     <= work_b_in;
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign stat.has_err   = (err_ff != STS_OK);
   assign stat.lt2       = (count_ff < CW'(2));
   assign stat.full      = (count_ff == CW'(STACK_DEPTH));
   assign stat.divz      = (top_ff == '0);
   assign stat.iter_done = (iter_ff == IW'(W - 1));
   assign stat.op        = op_ff;

   assign value  = out_value_ff;
   assign status = out_status_ff;

endmodule

// ===== sv/rpn_ctrl.sv =====
// sequencer for the postfix evaluator: classifies items, drives datapath
// commands and owns the result valid flag; depends on rpn_pkg
module rpn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        char_code,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  rpn_pkg::stat_type stat,
   output rpn_pkg::cmd_type  cmd
);
   import rpn_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // only the end marker waits for a pending result
            ready = !rsp_valid_ff || rsp_tready || (char_code != CHAR_EQUAL);
            if (ready && req_tvalid) begin
               if (char_code == CHAR_EQUAL) begin
                  cmd.emit = 1'b1;
               end else if (!stat.has_err) begin
                  if (is_operator(char_code)) begin
                     if (stat.lt2) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = STS_UNDER;
                     end else begin
                        cmd.fetch = 1'b1;
                        state_in  = ST_FETCH;
                     end
                  end else if (stat.full) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = STS_OVER;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
            end
         end
         ST_FETCH: begin
            // lower operand is on the ram read port this cycle
            if (stat.op == OP_DIV && stat.divz) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = STS_DIVZ;
               state_in     = ST_IDLE;
            end else begin
               cmd.exec = 1'b1;
               if (stat.op inside {OP_ADD, OP_SUB}) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ITER;
               end
            end
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            if (stat.iter_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_tready = ready;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/postfix_expression_evaluator_unit.sv =====
// postfix expression evaluator, one character per input item
// top level: joins rpn_ctrl and rpn_datapath; depends on rpn_pkg
//
// usage:
//   req channel carries one expression character per item. '+', '-', '*'
//   and '/' combine the two top stack entries, '=' ends the expression,
//   any other code pushes (code - 48). only '=' produces a rsp item.
//   rsp item holds the top of stack (zero on error) and a status:
//   0 ok, 1 underflow or empty, 2 overflow, 3 divide by zero.
// timing:
//   push, '=', underflow and overflow are handled in ST_IDLE alone; '+', '-' and
//   a divide by zero also pass ST_FETCH (ram read of the lower operand, then the
//   add or the check); '*' and '/' pass ST_FETCH, ST_ITER and ST_FINISH, stepped by the
//   shared one-bit-per-cycle shift-add multiplier and restoring divider. no new
//   character is taken outside ST_IDLE; a result is available the cycle after '=' is accepted.
// reset clears the stack count, the sticky error and the result valid flag.
// a stalled rsp holds its item; further characters are still taken until the
// next '=' arrives, which waits until the pending result is taken.
module postfix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] value, [33:32] status, rest zero
);
   import rpn_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [31:0] value;
   logic [1:0]  status;

   rpn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .char_code  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rpn_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .char_code (req_tdata),
      .stat      (stat),
      .value     (value),
      .status    (status)
   );

   assign rsp_tdata = {6'b0, status, value};

endmodule

// ===== sv/rpn_checker.sv =====
// port-level checks for the postfix evaluator, bound to the top level
// depends on rpn_pkg
module rpn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import rpn_pkg::*;

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a fresh result only follows an accepted end marker
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tdata == CHAR_EQUAL))
      else $error("result without end marker");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != STS_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero value with error status");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata != CHAR_EQUAL && (!rsp_tvalid || rsp_tready)
      |=> !rsp_tvalid)
      else $error("result from a character other than the end marker");

endmodule

bind postfix_expression_evaluator_unit rpn_checker u_rpn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/postfix_expression_evaluator_unit_tb.sv =====
// self-checking testbench for postfix_expression_evaluator_unit
// keeps its own operand stack to predict each '=' result; needs rpn_pkg and the top level
module postfix_expression_evaluator_unit_tb;
   import rpn_pkg::*;

   localparam int STACK_SLOTS = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  status;
   } eval_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   // predicted machine state
   logic [31:0] shadow_stack [STACK_SLOTS];
   int          shadow_depth;
   logic [1:0]  shadow_error;

   eval_result_type pending_results [$];
   int           mismatches;
   int           items_sent;
   int           quiet_cycles;
   bit           send_gaps_on;
   bit           recv_gaps_on;
   bit           hold_request;

   postfix_expression_evaluator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] char_code
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [31:0] value, [33:32] status
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic report_mismatch(input string field, input logic [31:0] expected,
                                  input logic [31:0] actual);
      $display("mismatch on %s: expected %0h, got %0h", field, expected, actual);
      mismatches++;
   endtask

   task automatic evaluate_char(input logic [7:0] c);
      logic [31:0] a, b, r, ma, mb, q;
      eval_result_type res;
      if (c == CHAR_EQUAL) begin
         res.value = 32'd0;
         res.status = shadow_error;
         if (shadow_error == STS_OK) begin
            if (shadow_depth == 0)
               res.status = STS_UNDER;
            else
               res.value = shadow_stack[shadow_depth - 1];
         end
         pending_results.push_back(res);
         shadow_depth = 0;
         shadow_error = STS_OK;
      end else if (shadow_error == STS_OK) begin
         if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH) begin
            if (shadow_depth < 2) begin
               shadow_error = STS_UNDER;
            end else begin
               a = shadow_stack[shadow_depth - 2];
               b = shadow_stack[shadow_depth - 1];
               if (c == CHAR_SLASH && b == 32'd0) begin
                  shadow_error = STS_DIVZ;
               end else begin
                  case (c)
                     CHAR_PLUS:  r = a + b;
                     CHAR_MINUS: r = a - b;
                     CHAR_STAR:  r = a * b;
                     default: begin
                        // truncate toward zero on magnitudes, min / -1 wraps back to min
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        r = (a[31] ^ b[31]) ? -q : q;
                     end
                  endcase
                  shadow_stack[shadow_depth - 2] = r;
                  shadow_depth--;
               end
            end
         end else if (shadow_depth >= STACK_SLOTS) begin
            shadow_error = STS_OVER;
         end else begin
            shadow_stack[shadow_depth] = {24'd0, c} - {24'd0, CHAR_ZERO};
            shadow_depth++;
         end
      end
   endtask

   task automatic send_char(input logic [7:0] c);
      @(negedge clock);
      while (send_gaps_on && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      evaluate_char(c);
      items_sent++;
   endtask

   function automatic logic [7:0] random_operand();
      logic [7:0] c;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         c = CHAR_ZERO;
      end else if (r < 55) begin
         c = CHAR_ZERO + 8'($urandom_range(0, 9));
      end else begin
         c = 8'($urandom_range(0, 255));
         while (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR ||
                c == CHAR_SLASH || c == CHAR_EQUAL)
            c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   function automatic logic [7:0] random_operator();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0:       c = CHAR_PLUS;
         1:       c = CHAR_MINUS;
         2:       c = CHAR_STAR;
         default: c = CHAR_SLASH;
      endcase
      return c;
   endfunction

   // random postfix expression; broken ones get noise and may lose their '='
   task automatic send_expression(input int max_operands, input bit well_formed,
                                  input bit push_first);
      int operands, pushed, depth;
      operands = $urandom_range(1, max_operands);
      pushed = 0;
      depth = 0;
      while (pushed < operands || depth > 1) begin
         if (pushed < operands && (depth < 2 || push_first || $urandom_range(0, 1))) begin
            send_char(random_operand());
            pushed++;
            depth++;
         end else begin
            send_char(random_operator());
            depth--;
         end
         if (!well_formed && $urandom_range(0, 5) == 0)
            send_char(8'($urandom_range(0, 255)));
      end
      if (well_formed || $urandom_range(0, 2) != 0)
         send_char(CHAR_EQUAL);
   endtask

   task automatic test_char_extremes();
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CHAR_EQUAL);     // two entries, top reported
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CHAR_PLUS);
      send_char(CHAR_EQUAL);
   endtask

   task automatic test_arithmetic();
      send_char(CHAR_ZERO + 8'd9);
      send_char(CHAR_ZERO + 8'd3);
      send_char(CHAR_MINUS);
      send_char(CHAR_ZERO + 8'd4);
      send_char(CHAR_STAR);
      send_char(CHAR_EQUAL);
      // -48 / 5 truncates toward zero
      send_char(8'h00);
      send_char(CHAR_ZERO + 8'd5);
      send_char(CHAR_SLASH);
      send_char(CHAR_EQUAL);
   endtask

   task automatic test_underflow();
      send_char(CHAR_PLUS);
      send_char(CHAR_ZERO + 8'd7);   // ignored after the error
      send_char(CHAR_EQUAL);
      send_char(CHAR_EQUAL);         // empty stack
   endtask

   task automatic test_overflow();
      repeat (STACK_SLOTS + 1)
         send_char(CHAR_ZERO + 8'd1);
      send_char(CHAR_PLUS);
      send_char(CHAR_EQUAL);
   endtask

   task automatic test_divide_by_zero();
      send_char(CHAR_ZERO + 8'd5);
      send_char(CHAR_ZERO);
      send_char(CHAR_SLASH);
      send_char(CHAR_PLUS);          // would be legal, but the first error sticks
      send_char(CHAR_EQUAL);
   endtask

   task automatic test_min_by_minus_one();
      // 128^4 * 8 = 2^31
      send_char(8'hB0);
      send_char(8'hB0);
      send_char(CHAR_STAR);
      send_char(8'hB0);
      send_char(CHAR_STAR);
      send_char(8'hB0);
      send_char(CHAR_STAR);
      send_char(CHAR_ZERO + 8'd8);
      send_char(CHAR_STAR);
      send_char(CHAR_ZERO);
      send_char(CHAR_ZERO + 8'd1);
      send_char(CHAR_MINUS);
      send_char(CHAR_SLASH);
      send_char(CHAR_EQUAL);
   endtask

   task automatic test_receiver_hold();
      hold_request = 1'b1;
      repeat (4)
         send_expression(5, 1'b1, 1'b0);
   endtask

   task automatic test_sender_pause();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (3)
         send_expression(4, 1'b1, 1'b0);
   endtask

   task automatic test_random_expressions(input int item_budget);
      int start;
      int phase;
      int unsigned r;
      start = items_sent;
      while (items_sent - start < item_budget) begin
         // middle third runs without any gaps
         phase = (items_sent - start) * 3 / item_budget;
         send_gaps_on = (phase != 1);
         recv_gaps_on = (phase != 1);
         r = $urandom_range(0, 99);
         if (r < 72)
            send_expression(8, 1'b1, 1'b0);
         else if (r < 84)
            send_expression(20, 1'b1, 1'($urandom_range(0, 1)));
         else
            send_expression(6, 1'b0, 1'b0);
      end
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
   endtask

   // receiver side, including the long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES)
               @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= !recv_gaps_on || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   always @(posedge clock) begin
      eval_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result value", 32'd0, rsp_tdata[31:0]);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tdata[31:0] !== exp_res.value)
               report_mismatch("value", exp_res.value, rsp_tdata[31:0]);
            if (rsp_tdata[33:32] !== exp_res.status)
               report_mismatch("status", {30'd0, exp_res.status}, {30'd0, rsp_tdata[33:32]});
            if (rsp_tdata[39:34] !== 6'd0)
               report_mismatch("padding", 32'd0, {26'd0, rsp_tdata[39:34]});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      shadow_depth = 0;
      shadow_error = STS_OK;
      mismatches = 0;
      items_sent = 0;
      quiet_cycles = 0;
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      hold_request = 1'b0;
      for (int i = 0; i < STACK_SLOTS; i++)
         shadow_stack[i] = 32'd0;
      repeat (4)
         @(negedge clock);
      reset <= 1'b0;

      test_char_extremes();
      test_arithmetic();
      test_underflow();
      test_overflow();
      test_divide_by_zero();
      test_min_by_minus_one();
      test_receiver_hold();
      test_sender_pause();
      test_random_expressions(500);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_datapath.sv
sv/rpn_ctrl.sv
sv/postfix_expression_evaluator_unit.sv
sv/rpn_checker.sv
sim/postfix_expression_evaluator_unit_tb.sv
